// ===== sv/rplt_pkg.sv =====
// rplt_pkg: shared types and constants for the rc pulse long-press toggle
// no dependencies; imported by rc_pulse_long_press_toggle_top and its testbench
package rplt_pkg;

    // field and register widths
    localparam int WIDTH_BITS_DEF = 12;
    localparam int TIME_BITS_DEF  = 32;
    localparam int TGT_BITS       = 12;
    localparam int HOLD_BITS      = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_IDX_BITS   = 1;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_WIDTH = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TIME    = 1'b1;

    // reset values of the registers
    localparam logic [TGT_BITS-1:0]  TARGET_WIDTH_RST = 12'd1500;
    localparam logic [HOLD_BITS-1:0] HOLD_TIME_RST    = 16'd1000;

    // sampling and tolerance constants
    localparam int SAMPLE_PERIOD_MS = 20;
    localparam int TARGET_TOL       = 50;
    localparam int STABLE_TOL       = 10;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_WAIT    = 2'd1,
        PH_HOLD    = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

endpackage

// ===== sv/rc_pulse_long_press_toggle_top.sv =====
// rc_pulse_long_press_toggle_top: long-press toggle switch driven by rc pulse widths
// depends on rplt_pkg for widths, register indexes, constants and phase_t
//
//  channel  direction  handshake                       payload
//  in       input      in_valid / in_ready             pulse_width, now_ms
//  out      output     out_valid / out_ready           toggled
//  cfg      input      cfg_we (no wait)                cfg_index, cfg_data
//
// one request per clock while the output is not stalled: input register, one pass of compare logic, result register
// a request is held in the input register, then its result is written to the result register
// a request waits in the input register while a result is stalled at the output
// reset clears all state but the input data registers to idle, switch off, target 1500, hold 1000
module rc_pulse_long_press_toggle_top
    import rplt_pkg::*;
#(
    parameter int WIDTH_BITS = WIDTH_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [WIDTH_BITS-1:0]    pulse_width,
    input  logic [TIME_BITS-1:0]     now_ms,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     toggled,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int CMP_BITS = ((WIDTH_BITS > TGT_BITS) ? WIDTH_BITS : TGT_BITS) + 1;
    localparam int TGT_KEEP = (WIDTH_BITS < TGT_BITS) ? WIDTH_BITS : TGT_BITS;
    localparam logic [TGT_BITS-1:0] TGT_MASK = TGT_BITS'((64'd1 << TGT_KEEP) - 64'd1);

    logic [TGT_BITS-1:0]   target_width_reg;
    logic [HOLD_BITS-1:0]  hold_time_reg;

    logic                  in_valid_reg;
    logic [WIDTH_BITS-1:0] pulse_width_reg;
    logic [TIME_BITS-1:0]  now_ms_reg;
    logic                  out_valid_reg;

    logic [TIME_BITS-1:0]  last_sample_reg;
    logic [TIME_BITS-1:0]  last_sample_next;
    logic [WIDTH_BITS-1:0] prev_width_reg;
    logic [WIDTH_BITS-1:0] prev_width_next;
    logic                  in_target_reg;
    logic                  in_target_next;
    phase_t                phase_reg;
    phase_t                phase_next;
    logic [TIME_BITS-1:0]  press_start_reg;
    logic [TIME_BITS-1:0]  press_start_next;
    logic                  switch_state_reg;
    logic                  switch_state_next;

    logic                  advance;
    logic [TIME_BITS-1:0]  sample_age;
    logic [TIME_BITS-1:0]  press_age;
    logic [CMP_BITS-1:0]   w_ext;
    logic [CMP_BITS-1:0]   tgt_ext;
    logic [CMP_BITS-1:0]   prev_ext;
    logic [CMP_BITS-1:0]   tgt_lo;
    logic [CMP_BITS-1:0]   tgt_hi;
    logic [CMP_BITS-1:0]   prev_lo;
    logic [CMP_BITS-1:0]   prev_hi;
    logic                  window_ok;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign toggled   = switch_state_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_width_reg <= TARGET_WIDTH_RST & TGT_MASK;
            hold_time_reg    <= HOLD_TIME_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET_WIDTH: target_width_reg <= cfg_data[TGT_BITS-1:0] & TGT_MASK;
                REG_HOLD_TIME:    hold_time_reg    <= cfg_data[HOLD_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pulse_width_reg <= pulse_width;
            now_ms_reg      <= now_ms;
        end
    end

    // sampling window test
    always_comb
    begin
        sample_age = now_ms_reg - last_sample_reg;
        press_age  = now_ms_reg - press_start_reg;
        w_ext      = CMP_BITS'(pulse_width_reg);
        tgt_ext    = CMP_BITS'(target_width_reg);
        prev_ext   = CMP_BITS'(prev_width_reg);
        // lower bounds saturate at zero
        tgt_lo     = (tgt_ext > CMP_BITS'(TARGET_TOL)) ? tgt_ext - CMP_BITS'(TARGET_TOL) : '0;
        tgt_hi     = tgt_ext + CMP_BITS'(TARGET_TOL);
        prev_lo    = (prev_ext > CMP_BITS'(STABLE_TOL)) ? prev_ext - CMP_BITS'(STABLE_TOL) : '0;
        prev_hi    = prev_ext + CMP_BITS'(STABLE_TOL);
        window_ok  = (w_ext >= tgt_lo) && (w_ext <= tgt_hi) &&
                     (w_ext >= prev_lo) && (w_ext <= prev_hi);

        last_sample_next = last_sample_reg;
        prev_width_next  = prev_width_reg;
        in_target_next   = in_target_reg;
        if (sample_age > TIME_BITS'(SAMPLE_PERIOD_MS))
        begin
            last_sample_next = now_ms_reg;
            prev_width_next  = pulse_width_reg;
            in_target_next   = window_ok;
        end
    end

    // phase machine, next state
    always_comb
    begin
        phase_next        = phase_reg;
        press_start_next  = press_start_reg;
        switch_state_next = switch_state_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                phase_next = PH_WAIT;
            end
            PH_WAIT:
            begin
                if (in_target_next)
                begin
                    press_start_next = now_ms_reg;
                    phase_next       = PH_HOLD;
                end
            end
            PH_HOLD:
            begin
                if (press_age > TIME_BITS'(hold_time_reg))
                begin
                    if (in_target_next)
                    begin
                        switch_state_next = !switch_state_reg;
                    end
                    phase_next = PH_RELEASE;
                end
            end
            PH_RELEASE:
            begin
                if (!in_target_next)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg  <= '0;
            prev_width_reg   <= '0;
            in_target_reg    <= 1'b0;
            phase_reg        <= PH_IDLE;
            press_start_reg  <= '0;
            switch_state_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                last_sample_reg  <= last_sample_next;
                prev_width_reg   <= prev_width_next;
                in_target_reg    <= in_target_next;
                phase_reg        <= phase_next;
                press_start_reg  <= press_start_next;
                switch_state_reg <= switch_state_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // checks
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(switch_state_reg) && $stable(phase_reg))
        else $error("state changed without a request");

    a_flip_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (switch_state_next != switch_state_reg) |->
            (phase_reg == PH_HOLD) && (phase_next == PH_RELEASE))
        else $error("switch flipped outside hold phase");

    a_hold_entry: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (phase_reg == PH_WAIT) && in_target_next |=>
            (phase_reg == PH_HOLD) && (press_start_reg == $past(now_ms_reg)))
        else $error("hold phase not entered with press start time");

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("input stalled with empty input register");

endmodule

// ===== tb/rc_pulse_long_press_toggle_top_tb.sv =====
// rc_pulse_long_press_toggle_top_tb: self-checking testbench for the rc pulse long-press toggle
// predicts the toggled flag per request and checks it against the block under idle/stall
// depends on rplt_pkg and rc_pulse_long_press_toggle_top
`timescale 1ns / 100ps

module rc_pulse_long_press_toggle_top_tb;
    import rplt_pkg::*;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [WIDTH_BITS_DEF-1:0] pulse_width = '0;
    logic [TIME_BITS_DEF-1:0]  now_ms = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b1;
    logic                     toggled;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = REG_TARGET_WIDTH;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int fail_count = 0;
    logic [31:0] stamp_ms = '0;

    // predicted block state
    logic [TGT_BITS-1:0]       model_target = TARGET_WIDTH_RST;
    logic [HOLD_BITS-1:0]      model_hold = HOLD_TIME_RST;
    logic [31:0]               model_last_sample = '0;
    logic [WIDTH_BITS_DEF-1:0] model_prev_width = '0;
    bit                        model_in_target = 1'b0;
    phase_t                    model_phase = PH_IDLE;
    logic [31:0]               model_press_start = '0;
    bit                        model_switch = 1'b0;

    bit toggled_expected[$];

    rc_pulse_long_press_toggle_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pulse_width (pulse_width),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .toggled     (toggled),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (toggled_expected.size() == 0)
            begin
                $error("toggled: unexpected result, actual %0b", toggled);
                fail_count++;
            end
            else
            begin
                bit want;
                want = toggled_expected.pop_front();
                if (toggled !== want)
                begin
                    $error("toggled: expected %0b, actual %0b", want, toggled);
                    fail_count++;
                end
            end
        end
    end

    function automatic bit in_window(input logic [11:0] v, input logic [11:0] centre,
                                     input int tol);
        int lo;
        lo = int'(centre) - tol;
        if (lo < 0)
            lo = 0;
        return (int'(v) >= lo) && (int'(v) <= int'(centre) + tol);
    endfunction

    task automatic toggle_model_step(input logic [11:0] w, input logic [31:0] t);
        logic [31:0] since_sample;
        logic [31:0] since_press;
        since_sample = t - model_last_sample;
        since_press = t - model_press_start;
        if (since_sample > 32'(SAMPLE_PERIOD_MS))
        begin
            model_last_sample = t;
            model_in_target = in_window(w, model_target, TARGET_TOL) &&
                              in_window(w, model_prev_width, STABLE_TOL);
            model_prev_width = w;
        end
        case (model_phase)
            PH_IDLE:
                model_phase = PH_WAIT;
            PH_WAIT:
                if (model_in_target)
                begin
                    model_press_start = t;
                    model_phase = PH_HOLD;
                end
            PH_HOLD:
                if (since_press > {16'd0, model_hold})
                begin
                    if (model_in_target)
                        model_switch = !model_switch;
                    model_phase = PH_RELEASE;
                end
            default:
                if (!model_in_target)
                    model_phase = PH_IDLE;
        endcase
        toggled_expected.push_back(model_switch);
    endtask

    // called and returns at a falling edge
    task automatic send_request(input logic [11:0] w, input logic [31:0] t);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        pulse_width = w;
        now_ms = t;
        do
            @(posedge clk);
        while (!in_ready);
        toggle_model_step(w, t);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_after(input int unsigned delta, input logic [11:0] w);
        stamp_ms += delta;
        send_request(w, stamp_ms);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (toggled_expected.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_config(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_TARGET_WIDTH)
            model_target = data[TGT_BITS-1:0];
        else
            model_hold = data[HOLD_BITS-1:0];
    endtask

    task automatic test_default_press();
        send_after(0, 12'd1500);
        send_after(21, 12'd1500);
        send_after(21, 12'd1505);
        send_after(21, 12'd1500);
        send_after(1000, 12'd1500);
        send_after(21, 12'd4095);
        send_after(21, 12'd0);
    endtask

    // window floors clamp at zero
    task automatic test_low_saturation();
        wait_idle();
        write_config(REG_TARGET_WIDTH, 16'hF000);
        write_config(REG_HOLD_TIME, 16'd0);
        send_after(21, 12'd0);
        send_after(21, 12'd9);
        send_after(21, 12'd0);
        send_after(21, 12'd51);
        send_after(21, 12'd50);
        send_after(5, 12'd3);
    endtask

    // window ceilings above the field range
    task automatic test_high_bound();
        wait_idle();
        write_config(REG_TARGET_WIDTH, 16'h0FFF);
        write_config(REG_HOLD_TIME, 16'hFFFF);
        send_after(21, 12'd4095);
        send_after(21, 12'd4090);
        send_after(21, 12'd4095);
        send_after(21, 12'd4095);
    endtask

    task automatic test_time_wrap();
        wait_idle();
        write_config(REG_TARGET_WIDTH, 16'd1500);
        write_config(REG_HOLD_TIME, 16'd40);
        stamp_ms = 32'hFFFF_FFC0;
        send_after(0, 12'd1500);
        send_after(21, 12'd1500);
        send_after(21, 12'd1502);
        send_after(21, 12'd1500);
        send_after(21, 12'd1500);
        send_after(21, 12'd1500);
        send_after(21, 12'd1400);
    endtask

    // press episodes with jitter, releases and noise
    task automatic run_random_presses(input int n_items);
        int sent;
        int len;
        int mode;
        int k;
        int w;
        sent = 0;
        while (sent < n_items)
        begin
            mode = $urandom_range(9);
            len = $urandom_range(2, 16);
            for (k = 0; k < len && sent < n_items; k++)
            begin
                if (mode < 6)
                    w = int'(model_target) + int'($urandom_range(0, 10)) - 5;
                else if (mode < 8)
                begin
                    if ($urandom_range(1) == 0)
                        w = 0;
                    else if (model_target >= 2048)
                        w = int'(model_target) - 60 - int'($urandom_range(0, 200));
                    else
                        w = int'(model_target) + 60 + int'($urandom_range(0, 200));
                end
                else
                    w = $urandom_range(0, 4095);
                if (w < 0)
                    w = 0;
                if (w > 4095)
                    w = 4095;
                if (mode == 9 && $urandom_range(3) == 0)
                    stamp_ms = $urandom;
                else if ($urandom_range(4) == 0)
                    stamp_ms += $urandom_range(0, 20);
                else
                    stamp_ms += $urandom_range(21, 80);
                send_request(12'(w), stamp_ms);
                sent++;
            end
        end
    endtask

    task automatic test_random_no_idle();
        wait_idle();
        src_idle_pct = 0;
        sink_stall_pct = 0;
        write_config(REG_TARGET_WIDTH, 16'd1500);
        write_config(REG_HOLD_TIME, 16'd100);
        run_random_presses(250);
    endtask

    task automatic test_random_sender_idle();
        wait_idle();
        src_idle_pct = 68;
        sink_stall_pct = 0;
        write_config(REG_TARGET_WIDTH, 16'hF000);
        write_config(REG_HOLD_TIME, 16'($urandom_range(0, 300)));
        run_random_presses(250);
    endtask

    task automatic test_random_receiver_stall();
        wait_idle();
        src_idle_pct = 0;
        sink_stall_pct = 68;
        write_config(REG_TARGET_WIDTH, 16'($urandom_range(0, 65535)));
        write_config(REG_HOLD_TIME, 16'($urandom_range(0, 300)));
        run_random_presses(250);
    endtask

    task automatic test_random_both_idle();
        wait_idle();
        src_idle_pct = 34;
        sink_stall_pct = 34;
        write_config(REG_TARGET_WIDTH, 16'h0FFF);
        write_config(REG_HOLD_TIME, 16'hFFFF);
        run_random_presses(125);
        wait_idle();
        write_config(REG_TARGET_WIDTH, 16'($urandom_range(0, 65535)));
        write_config(REG_HOLD_TIME, 16'd50);
        run_random_presses(125);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_default_press();
        test_low_saturation();
        test_high_bound();
        test_time_wrap();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();

        wait_idle();
        if (fail_count == 0)
            $display("rc_pulse_long_press_toggle_top_tb OK");
        else
            $display("rc_pulse_long_press_toggle_top_tb NOT OK");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("rc_pulse_long_press_toggle_top_tb NOT OK");
        $finish;
    end

endmodule
